@@ rtl/core/adll_pkg.sv @@
// ----------------------------------------------------------------------------
// adll_pkg
// Shared codes and the result record of the array doubly linked list block.
// ----------------------------------------------------------------------------
package adll_pkg;

    // operation codes carried by an input item
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    // status codes carried by a result item
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_BAD  = 2'd2,
        STATUS_MISS = 2'd3
    } status_t;

    // one result item as it leaves the sequencer
    typedef struct packed {
        logic [7:0] slot;
        status_t    status;
        logic [7:0] size;
    } adll_result_t;

endpackage

@@ rtl/core/array_doubly_linked_list.sv @@
// ----------------------------------------------------------------------------
// array_doubly_linked_list
// Doubly linked list in a slot memory with a free list; insert, delete, search.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one operation per item: insert s_value after slot
//   s_slot_index (0 means at the head), delete slot s_slot_index, or search
//   for s_value from the head. m_ channel returns one result item per
//   operation: slot, status and list size after the operation.
//   Items are handled one at a time on a single slot memory (one read, one
//   write per cycle, registered read), so the rate is set by the dependent
//   memory accesses of each operation. An insert reads the predecessor and
//   the free head, writes the new entry, then links successor and predecessor;
//   a delete releases the slot, then relinks predecessor and successor; a
//   search visits elements from the head. The next item is accepted in the
//   cycle after the result enters the output register.
//   Reset clears the list at once: a high-water mark tells never-used slots
//   apart, so no clearing pass runs. When the receiver stalls, the result
//   waits in the output register; the next item is still accepted and
//   worked on, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module array_doubly_linked_list #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [7:0]  s_slot_index,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_result_slot,
    output logic [1:0]  m_status,
    output logic [7:0]  m_list_size
);
    import adll_pkg::*;

    logic         res_valid;
    logic         res_ready;
    adll_result_t res;

    // operation sequencer with the slot memory
    adll_seq #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_slot_index (s_slot_index),
        .s_value      (s_value),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // result output register
    adll_out_buf u_out_buf (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_slot (m_result_slot),
        .m_status      (m_status),
        .m_list_size   (m_list_size)
    );

endmodule

@@ rtl/core/adll_ram.sv @@
// ----------------------------------------------------------------------------
// adll_ram
// Generic simple dual port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module adll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/adll_seq.sv @@
// ----------------------------------------------------------------------------
// adll_seq
// Operation sequencer: walks each item through read-modify-write steps on the
// slot memory and keeps head, free head, element count and high-water mark.
// ----------------------------------------------------------------------------
module adll_seq #(
    parameter int CAPACITY    = 256,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_op,
    input  logic [7:0]            s_slot_index,
    input  logic [31:0]           s_value,
    output logic                  res_valid,
    input  logic                  res_ready,
    output adll_pkg::adll_result_t res
);
    import adll_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int VW = VALUE_WIDTH;
    localparam logic [SW:0]   CAP_W     = (SW+1)'(CAPACITY);
    localparam logic [SW-1:0] MAX_COUNT = SW'(CAPACITY - 1);

    // one slot entry as stored in the memory
    typedef struct packed {
        logic          in_use;
        logic [SW-1:0] prev;
        logic [SW-1:0] next;
        logic [VW-1:0] data;
    } entry_t;

    localparam int EW = $bits(entry_t);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b00000000001,
        S_DECODE    = 11'b00000000010,
        S_INS_PRED  = 11'b00000000100,
        S_INS_FREE  = 11'b00000001000,
        S_INS_AFTER = 11'b00000010000,
        S_INS_LINK  = 11'b00000100000,
        S_DEL_SLOT  = 11'b00001000000,
        S_DEL_PREV  = 11'b00010000000,
        S_DEL_NEXT  = 11'b00100000000,
        S_SEARCH    = 11'b01000000000,
        S_RESP      = 11'b10000000000
    } state_t;

    state_t        state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [7:0]    slot_reg, slot_next;
    logic [VW-1:0] val_reg, val_next;
    logic [SW-1:0] head_reg, head_next;
    logic [SW-1:0] free_reg, free_next;
    logic [SW-1:0] count_reg, count_next;
    logic [SW:0]   hwm_reg, hwm_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] aux_reg, aux_next;
    entry_t        ent_reg, ent_next;
    logic [SW-1:0] res_slot_reg, res_slot_next;
    status_t       res_status_reg, res_status_next;

    logic          wr_en;
    logic [SW-1:0] wr_addr;
    entry_t        wr_entry;
    logic [SW-1:0] rd_addr;
    logic [EW-1:0] rd_data;
    entry_t        rd_entry;

    logic [31:0]   slot_ext;
    logic [SW-1:0] slot_w;
    logic          slot_zero;
    logic          slot_in_range;
    logic          slot_live;
    logic [SW:0]   free_inc;
    logic [SW-1:0] free_fresh_next;
    logic          free_is_fresh;
    logic [63:0]   val_ext;
    logic [31:0]   res_slot_ext;
    logic [31:0]   count_ext;

    // slot memory: in-use flag, links and value of every slot
    adll_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry = rd_data;

    // slot index decode; slots at or above the high-water mark were never written
    assign slot_ext      = 32'(slot_reg);
    assign slot_w        = slot_ext[SW-1:0];
    assign slot_zero     = (slot_reg == 8'd0);
    assign slot_in_range = (slot_ext < 32'(CAPACITY));
    assign slot_live     = ({1'b0, slot_w} < hwm_reg) && rd_entry.in_use;

    // never-used free slots still chain to the following slot
    assign free_inc        = {1'b0, free_reg} + 1'b1;
    assign free_fresh_next = (free_inc == CAP_W) ? '0 : free_inc[SW-1:0];
    assign free_is_fresh   = !({1'b0, free_reg} < hwm_reg);

    assign val_ext = 64'(s_value);

    // operation sequencer
    always_comb begin
        state_next      = state_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        val_next        = val_reg;
        head_next       = head_reg;
        free_next       = free_reg;
        count_next      = count_reg;
        hwm_next        = hwm_reg;
        cur_next        = cur_reg;
        aux_next        = aux_reg;
        ent_next        = ent_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_entry        = '0;
        rd_addr         = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_op;
                    slot_next  = s_slot_index;
                    val_next   = val_ext[VW-1:0];
                    state_next = S_DECODE;
                end
            end

            S_DECODE: begin
                res_slot_next   = '0;
                res_status_next = STATUS_OK;
                state_next      = S_RESP;
                unique case (op_reg)
                    OP_INSERT: begin
                        if (free_reg == '0) begin
                            res_status_next = STATUS_FULL;
                        end else if (!slot_zero && !slot_in_range) begin
                            res_status_next = STATUS_BAD;
                        end else begin
                            rd_addr    = slot_w;
                            state_next = S_INS_PRED;
                        end
                    end
                    OP_DELETE: begin
                        if (slot_zero || !slot_in_range) begin
                            res_status_next = STATUS_BAD;
                        end else begin
                            rd_addr    = slot_w;
                            state_next = S_DEL_SLOT;
                        end
                    end
                    OP_SEARCH: begin
                        if (head_reg == '0) begin
                            res_status_next = STATUS_MISS;
                        end else begin
                            rd_addr    = head_reg;
                            cur_next   = head_reg;
                            state_next = S_SEARCH;
                        end
                    end
                    default: begin
                        res_status_next = STATUS_OK;
                    end
                endcase
            end

            // predecessor entry is back: check it and find the successor
            S_INS_PRED: begin
                if (!slot_zero && !slot_live) begin
                    res_status_next = STATUS_BAD;
                    state_next      = S_RESP;
                end else begin
                    ent_next   = rd_entry;
                    cur_next   = slot_zero ? head_reg : rd_entry.next;
                    rd_addr    = free_reg;
                    state_next = S_INS_FREE;
                end
            end

            // free head entry is back: note the new free head, write the new entry
            S_INS_FREE: begin
                aux_next   = free_is_fresh ? free_fresh_next : rd_entry.next;
                wr_en      = 1'b1;
                wr_addr    = free_reg;
                wr_entry   = '{in_use: 1'b1, prev: slot_w, next: cur_reg, data: val_reg};
                rd_addr    = cur_reg;
                state_next = S_INS_AFTER;
            end

            // successor points back to the new entry
            S_INS_AFTER: begin
                if (cur_reg != '0) begin
                    wr_en         = 1'b1;
                    wr_addr       = cur_reg;
                    wr_entry      = rd_entry;
                    wr_entry.prev = free_reg;
                end
                state_next = S_INS_LINK;
            end

            // predecessor or head points to the new entry
            S_INS_LINK: begin
                if (slot_zero) begin
                    head_next = free_reg;
                end else begin
                    wr_en         = 1'b1;
                    wr_addr       = slot_w;
                    wr_entry      = ent_reg;
                    wr_entry.next = free_reg;
                end
                if (free_is_fresh) begin
                    hwm_next = hwm_reg + 1'b1;
                end
                free_next     = aux_reg;
                count_next    = count_reg + 1'b1;
                res_slot_next = free_reg;
                state_next    = S_RESP;
            end

            // entry to delete is back: release it to the free list
            S_DEL_SLOT: begin
                if (!slot_live) begin
                    res_status_next = STATUS_BAD;
                    state_next      = S_RESP;
                end else begin
                    ent_next   = rd_entry;
                    wr_en      = 1'b1;
                    wr_addr    = slot_w;
                    wr_entry   = '{in_use: 1'b0, prev: '0, next: free_reg,
                                   data: rd_entry.data};
                    rd_addr    = rd_entry.prev;
                    state_next = S_DEL_PREV;
                end
            end

            // predecessor skips the deleted entry
            S_DEL_PREV: begin
                if (ent_reg.prev != '0) begin
                    wr_en         = 1'b1;
                    wr_addr       = ent_reg.prev;
                    wr_entry      = rd_entry;
                    wr_entry.next = ent_reg.next;
                end
                rd_addr    = ent_reg.next;
                state_next = S_DEL_NEXT;
            end

            // successor skips the deleted entry
            S_DEL_NEXT: begin
                if (ent_reg.next != '0) begin
                    wr_en         = 1'b1;
                    wr_addr       = ent_reg.next;
                    wr_entry      = rd_entry;
                    wr_entry.prev = ent_reg.prev;
                end
                if (ent_reg.prev == '0) begin
                    head_next = ent_reg.next;
                end
                free_next  = slot_w;
                count_next = count_reg - 1'b1;
                state_next = S_RESP;
            end

            // one list element per cycle
            S_SEARCH: begin
                if (rd_entry.data == val_reg) begin
                    res_slot_next = cur_reg;
                    state_next    = S_RESP;
                end else if (rd_entry.next == '0) begin
                    res_status_next = STATUS_MISS;
                    state_next      = S_RESP;
                end else begin
                    rd_addr  = rd_entry.next;
                    cur_next = rd_entry.next;
                end
            end

            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            free_reg  <= SW'(1);
            count_reg <= '0;
            hwm_reg   <= (SW+1)'(1);
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            free_reg  <= free_next;
            count_reg <= count_next;
            hwm_reg   <= hwm_next;
        end
    end

    // item and working payload
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        slot_reg       <= slot_next;
        val_reg        <= val_next;
        cur_reg        <= cur_next;
        aux_reg        <= aux_next;
        ent_reg        <= ent_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
    end

    // handshakes and result record
    assign s_ready      = (state_reg == S_IDLE);
    assign res_valid    = (state_reg == S_RESP);
    assign res_slot_ext = 32'(res_slot_reg);
    assign count_ext    = 32'(count_reg);
    assign res.slot     = res_slot_ext[7:0];
    assign res.status   = res_status_reg;
    assign res.size     = count_ext[7:0];

    // count stays below the slot count
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, count_reg} < CAP_W)
        else $error("element count out of range");

    // empty free list means every slot but the sentinel is in the list
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_reg == '0) |-> (count_reg == MAX_COUNT))
        else $error("free list empty but list not full");

    // head is the sentinel exactly when the list is empty
    a_head_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_reg == '0) == (count_reg == '0))
        else $error("head and element count disagree");

    // the sentinel entry is never written
    a_no_sentinel_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (wr_addr != '0))
        else $error("write to sentinel slot");

    // free head never lies beyond the high-water mark
    a_free_hwm: assert property (@(posedge aclk) disable iff (!aresetn)
        (free_reg != '0) |-> ({1'b0, free_reg} <= hwm_reg))
        else $error("free head beyond high-water mark");

endmodule

@@ rtl/core/adll_out_buf.sv @@
// ----------------------------------------------------------------------------
// adll_out_buf
// Result output register: holds one result item for the receiver so the
// sequencer can go on with the next item.
// ----------------------------------------------------------------------------
module adll_out_buf (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   res_valid,
    output logic                   res_ready,
    input  adll_pkg::adll_result_t res,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_result_slot,
    output logic [1:0]             m_status,
    output logic [7:0]             m_list_size
);
    import adll_pkg::*;

    logic         m_valid_reg, m_valid_next;
    adll_result_t data_reg;

    // free when empty or when the held item leaves this cycle
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // payload loads only on an accepted item
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            data_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_result_slot = data_reg.slot;
    assign m_status      = data_reg.status;
    assign m_list_size   = data_reg.size;

endmodule
